[rtl/hylt_pkg.sv]
// ----------------------------------------------------------------------------
// hylt_pkg
// Shared types and constants for the lut-based hdr yuv tone mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package hylt_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned OPCODE_BITS = 3;
  localparam int unsigned LUT_INDEX_BITS_DEF = 8;
  localparam int unsigned CORR_ADDR_BITS = 2 * BYTE_BITS;
  localparam int unsigned LUMA_LANES = 4;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_PROCESS = 3'd0,
    OP_LUMA    = 3'd1,
    OP_CB      = 3'd2,
    OP_CR      = 3'd3,
    OP_CORR    = 3'd4
  } opcode_e;

  // lanes: 0 top left, 1 top right, 2 bottom left, 3 bottom right
  typedef logic [LUMA_LANES-1:0][BYTE_BITS-1:0] luma4_t;

  typedef struct packed {
    logic adv;
    logic wr;
  } stage_ctrl_t;

  typedef struct packed {
    logic adv;
    logic wr_cb;
    logic wr_cr;
  } chroma_ctrl_t;

endpackage

`default_nettype wire

[rtl/hylt_if.sv]
// ----------------------------------------------------------------------------
// hylt channel interfaces
// Valid/ready channels for input blocks and tone-mapped results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hylt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [hylt_pkg::OPCODE_BITS-1:0]     opcode;
  logic [hylt_pkg::BYTE_BITS-1:0]       table_row;
  logic [hylt_pkg::BYTE_BITS-1:0]       table_column;
  logic [hylt_pkg::BYTE_BITS-1:0]       table_value;
  logic [hylt_pkg::SAMPLE_BITS-1:0]     luma_top_left;
  logic [hylt_pkg::SAMPLE_BITS-1:0]     luma_top_right;
  logic [hylt_pkg::SAMPLE_BITS-1:0]     luma_bottom_left;
  logic [hylt_pkg::SAMPLE_BITS-1:0]     luma_bottom_right;
  logic [hylt_pkg::SAMPLE_BITS-1:0]     cb_sample;
  logic [hylt_pkg::SAMPLE_BITS-1:0]     cr_sample;

  modport source (
    output valid, opcode, table_row, table_column, table_value,
    output luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    output cb_sample, cr_sample,
    input  ready
  );

  modport sink (
    input  valid, opcode, table_row, table_column, table_value,
    input  luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    input  cb_sample, cr_sample,
    output ready
  );
endinterface

interface hylt_out_if;
  logic                           valid;
  logic                           ready;
  logic [hylt_pkg::BYTE_BITS-1:0] out_top_left;
  logic [hylt_pkg::BYTE_BITS-1:0] out_top_right;
  logic [hylt_pkg::BYTE_BITS-1:0] out_bottom_left;
  logic [hylt_pkg::BYTE_BITS-1:0] out_bottom_right;
  logic [hylt_pkg::BYTE_BITS-1:0] out_cb;
  logic [hylt_pkg::BYTE_BITS-1:0] out_cr;

  modport source (
    output valid, out_top_left, out_top_right, out_bottom_left, out_bottom_right,
    output out_cb, out_cr,
    input  ready
  );

  modport sink (
    input  valid, out_top_left, out_top_right, out_bottom_left, out_bottom_right,
    input  out_cb, out_cr,
    output ready
  );
endinterface

`default_nettype wire

[rtl/hylt_curve_stage.sv]
// ----------------------------------------------------------------------------
// hylt_curve_stage
// Luma curve, one copy per luma lane, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module hylt_curve_stage #(
  parameter int unsigned LUT_INDEX_BITS = hylt_pkg::LUT_INDEX_BITS_DEF
) (
  input  wire                                                     clk_i,
  input  hylt_pkg::stage_ctrl_t                                   ctrl_i,
  input  wire  [LUT_INDEX_BITS-1:0]                               wr_idx_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]                          wr_data_i,
  input  wire  [hylt_pkg::LUMA_LANES-1:0][LUT_INDEX_BITS-1:0]     rd_idx_i,
  output hylt_pkg::luma4_t                                        luma_o
);

  localparam int unsigned LutDepth = 1 << LUT_INDEX_BITS;

  for (genvar g = 0; g < hylt_pkg::LUMA_LANES; g++) begin : g_lane
    logic [hylt_pkg::BYTE_BITS-1:0] mem [LutDepth];
    logic [hylt_pkg::BYTE_BITS-1:0] rd_q;

    // every copy takes the same write
    always_ff @(posedge clk_i) begin
      if (ctrl_i.wr) begin
        mem[wr_idx_i] <= wr_data_i;
      end
      if (ctrl_i.adv) begin
        rd_q <= mem[rd_idx_i[g]];
      end
    end

    assign luma_o[g] = rd_q;
  end

endmodule

`default_nettype wire

[rtl/hylt_chroma_stage.sv]
// ----------------------------------------------------------------------------
// hylt_chroma_stage
// Luma average and the two 2d chroma tables, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module hylt_chroma_stage #(
  parameter int unsigned LUT_INDEX_BITS = hylt_pkg::LUT_INDEX_BITS_DEF
) (
  input  wire                                 clk_i,
  input  hylt_pkg::chroma_ctrl_t              ctrl_i,
  input  hylt_pkg::luma4_t                    luma_i,
  input  wire  [LUT_INDEX_BITS-1:0]           cb_idx_i,
  input  wire  [LUT_INDEX_BITS-1:0]           cr_idx_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]      wr_row_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]      wr_col_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]      wr_data_i,
  output logic [hylt_pkg::BYTE_BITS-1:0]      cb_o,
  output logic [hylt_pkg::BYTE_BITS-1:0]      cr_o
);

  localparam int unsigned AddrBits = hylt_pkg::BYTE_BITS + LUT_INDEX_BITS;
  localparam int unsigned Depth = 1 << AddrBits;
  localparam int unsigned SumBits = hylt_pkg::BYTE_BITS + 2;

  logic [hylt_pkg::BYTE_BITS-1:0] cb_mem [Depth];
  logic [hylt_pkg::BYTE_BITS-1:0] cr_mem [Depth];
  logic [SumBits-1:0]             sum;
  logic [hylt_pkg::BYTE_BITS-1:0] avg;
  logic [AddrBits-1:0]            cb_raddr;
  logic [AddrBits-1:0]            cr_raddr;
  logic [AddrBits-1:0]            waddr;
  logic [hylt_pkg::BYTE_BITS-1:0] cb_q;
  logic [hylt_pkg::BYTE_BITS-1:0] cr_q;

  assign sum = SumBits'(luma_i[0]) + SumBits'(luma_i[1])
             + SumBits'(luma_i[2]) + SumBits'(luma_i[3]);
  // divide by four, always fits a byte
  assign avg = sum[SumBits-1:2];

  assign cb_raddr = {avg, cb_idx_i};
  assign cr_raddr = {avg, cr_idx_i};
  // column wraps or zero-extends to the index width
  assign waddr = {wr_row_i, LUT_INDEX_BITS'(wr_col_i)};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_cb) begin
      cb_mem[waddr] <= wr_data_i;
    end
    if (ctrl_i.adv) begin
      cb_q <= cb_mem[cb_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_cr) begin
      cr_mem[waddr] <= wr_data_i;
    end
    if (ctrl_i.adv) begin
      cr_q <= cr_mem[cr_raddr];
    end
  end

  assign cb_o = cb_q;
  assign cr_o = cr_q;

endmodule

`default_nettype wire

[rtl/hylt_corr_stage.sv]
// ----------------------------------------------------------------------------
// hylt_corr_stage
// Cr-driven luma correction table, one copy per luma lane.
// ----------------------------------------------------------------------------
`default_nettype none

module hylt_corr_stage (
  input  wire                                 clk_i,
  input  hylt_pkg::stage_ctrl_t               ctrl_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]      cr_i,
  input  hylt_pkg::luma4_t                    luma_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]      wr_row_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]      wr_col_i,
  input  wire  [hylt_pkg::BYTE_BITS-1:0]      wr_data_i,
  output hylt_pkg::luma4_t                    luma_o
);

  localparam int unsigned Depth = 1 << hylt_pkg::CORR_ADDR_BITS;

  logic [hylt_pkg::CORR_ADDR_BITS-1:0] waddr;

  assign waddr = {wr_row_i, wr_col_i};

  for (genvar g = 0; g < hylt_pkg::LUMA_LANES; g++) begin : g_lane
    logic [hylt_pkg::BYTE_BITS-1:0]      mem [Depth];
    logic [hylt_pkg::CORR_ADDR_BITS-1:0] raddr;
    logic [hylt_pkg::BYTE_BITS-1:0]      rd_q;

    assign raddr = {cr_i, luma_i[g]};

    always_ff @(posedge clk_i) begin
      if (ctrl_i.wr) begin
        mem[waddr] <= wr_data_i;
      end
      if (ctrl_i.adv) begin
        rd_q <= mem[raddr];
      end
    end

    assign luma_o[g] = rd_q;
  end

endmodule

`default_nettype wire

[rtl/hdr_yuv_lut_tone_mapper.sv]
// ----------------------------------------------------------------------------
// hdr_yuv_lut_tone_mapper
// Table-driven hdr to sdr tone mapping of 4:2:0 yuv blocks, three stages.
// ----------------------------------------------------------------------------
// usage
//   in_i carries one transaction per 2x2 block (opcode process) or one table
//   entry write (opcodes luma curve, cb, cr, luma correction). out_o carries
//   one transaction per process block: four corrected lumas, cb and cr.
//   write transactions and unused opcodes give no output transaction.
// throughput and table copies
//   a block accepted on in_i passes the curve, chroma and correction
//   stage registers in that order before it is presented on out_o. one
//   transaction per cycle is sustained while out_o takes results; each
//   table copy sees one read and at most one write per cycle, with the
//   luma curve and correction table held four times over (one per luma lane).
// ordering
//   each table is written in the stage that reads it, so a write is seen by
//   every transaction that follows it on in_i.
// reset and stall
//   reset empties the pipeline; table contents are not cleared and must be
//   written before use. when out_o stalls, each stage holds until the stage
//   ahead frees up; in_i.ready drops only once all three stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module hdr_yuv_lut_tone_mapper #(
  parameter int unsigned LUT_INDEX_BITS = hylt_pkg::LUT_INDEX_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  hylt_in_if.sink            in_i,
  hylt_out_if.source         out_o
);

  localparam int unsigned SampleBits = hylt_pkg::SAMPLE_BITS;

  // stage advance enables, first stage first
  logic adv1;
  logic adv2;
  logic adv3;

  // stage 1: luma curve read data plus sideband
  logic                                v1_q;
  logic [hylt_pkg::OPCODE_BITS-1:0]    op1_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      row1_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      col1_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      val1_q;
  logic [LUT_INDEX_BITS-1:0]           cb_idx1_q;
  logic [LUT_INDEX_BITS-1:0]           cr_idx1_q;
  hylt_pkg::luma4_t                    luma1;

  // stage 2: chroma read data plus sideband
  logic                                v2_q;
  logic [hylt_pkg::OPCODE_BITS-1:0]    op2_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      row2_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      col2_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      val2_q;
  hylt_pkg::luma4_t                    luma2_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      cb2;
  logic [hylt_pkg::BYTE_BITS-1:0]      cr2;

  // stage 3: output register
  logic                                v3_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      cb3_q;
  logic [hylt_pkg::BYTE_BITS-1:0]      cr3_q;
  hylt_pkg::luma4_t                    luma3;

  logic                                    in_take;
  logic [hylt_pkg::LUMA_LANES-1:0][LUT_INDEX_BITS-1:0] curve_idx;
  hylt_pkg::stage_ctrl_t                   curve_ctrl;
  hylt_pkg::chroma_ctrl_t                  chroma_ctrl;
  hylt_pkg::stage_ctrl_t                   corr_ctrl;

  // a stage loads when it is empty or its item moves on
  assign adv3 = !v3_q || out_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_i.ready = adv1;
  assign in_take = in_i.valid && adv1;

  // top index bits of each luma sample
  assign curve_idx[0] = in_i.luma_top_left[SampleBits-1 -: LUT_INDEX_BITS];
  assign curve_idx[1] = in_i.luma_top_right[SampleBits-1 -: LUT_INDEX_BITS];
  assign curve_idx[2] = in_i.luma_bottom_left[SampleBits-1 -: LUT_INDEX_BITS];
  assign curve_idx[3] = in_i.luma_bottom_right[SampleBits-1 -: LUT_INDEX_BITS];

  assign curve_ctrl.adv = adv1;
  assign curve_ctrl.wr  = in_take && (in_i.opcode == hylt_pkg::OP_LUMA);

  assign chroma_ctrl.adv   = adv2;
  assign chroma_ctrl.wr_cb = v1_q && adv2 && (op1_q == hylt_pkg::OP_CB);
  assign chroma_ctrl.wr_cr = v1_q && adv2 && (op1_q == hylt_pkg::OP_CR);

  assign corr_ctrl.adv = adv3;
  assign corr_ctrl.wr  = v2_q && adv3 && (op2_q == hylt_pkg::OP_CORR);

  hylt_curve_stage #(
    .LUT_INDEX_BITS (LUT_INDEX_BITS)
  ) u_curve (
    .clk_i     (clk_i),
    .ctrl_i    (curve_ctrl),
    // curve write index is {row, column} wrapped to the table size
    .wr_idx_i  (LUT_INDEX_BITS'({in_i.table_row, in_i.table_column})),
    .wr_data_i (in_i.table_value),
    .rd_idx_i  (curve_idx),
    .luma_o    (luma1)
  );

  hylt_chroma_stage #(
    .LUT_INDEX_BITS (LUT_INDEX_BITS)
  ) u_chroma (
    .clk_i     (clk_i),
    .ctrl_i    (chroma_ctrl),
    .luma_i    (luma1),
    .cb_idx_i  (cb_idx1_q),
    .cr_idx_i  (cr_idx1_q),
    .wr_row_i  (row1_q),
    .wr_col_i  (col1_q),
    .wr_data_i (val1_q),
    .cb_o      (cb2),
    .cr_o      (cr2)
  );

  hylt_corr_stage u_corr (
    .clk_i     (clk_i),
    .ctrl_i    (corr_ctrl),
    .cr_i      (cr2),
    .luma_i    (luma2_q),
    .wr_row_i  (row2_q),
    .wr_col_i  (col2_q),
    .wr_data_i (val2_q),
    .luma_o    (luma3)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_i.valid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      // only process blocks leave the pipeline as results
      if (adv3) begin
        v3_q <= v2_q && (op2_q == hylt_pkg::OP_PROCESS);
      end
    end
  end

  // sideband payload, no reset
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      op1_q     <= in_i.opcode;
      row1_q    <= in_i.table_row;
      col1_q    <= in_i.table_column;
      val1_q    <= in_i.table_value;
      cb_idx1_q <= in_i.cb_sample[SampleBits-1 -: LUT_INDEX_BITS];
      cr_idx1_q <= in_i.cr_sample[SampleBits-1 -: LUT_INDEX_BITS];
    end
    if (adv2) begin
      op2_q   <= op1_q;
      row2_q  <= row1_q;
      col2_q  <= col1_q;
      val2_q  <= val1_q;
      luma2_q <= luma1;
    end
    if (adv3) begin
      cb3_q <= cb2;
      cr3_q <= cr2;
    end
  end

  assign out_o.valid            = v3_q;
  assign out_o.out_top_left     = luma3[0];
  assign out_o.out_top_right    = luma3[1];
  assign out_o.out_bottom_left  = luma3[2];
  assign out_o.out_bottom_right = luma3[3];
  assign out_o.out_cb           = cb3_q;
  assign out_o.out_cr           = cr3_q;

  // a new result only ever comes from a process block in stage 2
  a_result_from_process: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q && (op2_q == hylt_pkg::OP_PROCESS)))
    else $error("result appeared without a process block behind it");

  // input backpressure only when every stage holds an item
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q))
    else $error("input stalled while the pipeline has a bubble");

  // a stalled stage 1 keeps its item
  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv2) |=> (v1_q && $stable(op1_q) && $stable(cb_idx1_q)))
    else $error("stage 1 lost or changed its item during a stall");

  // the cb and cr tables are never both written in the same cycle
  a_single_chroma_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(chroma_ctrl.wr_cb && chroma_ctrl.wr_cr))
    else $error("cb and cr tables written by one transaction");

endmodule

`default_nettype wire
